/* rtl/xed_pkg.sv */
// Shared types and constants for the XML entity decoder.
package xed_pkg;

    // Error codes reported in a status beat
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_UNTERM   = 3'd1,
        ERR_UNSUPP   = 3'd2,
        ERR_EMPTY    = 3'd3,
        ERR_BAD_DEC  = 3'd4,
        ERR_BAD_HEX  = 3'd5,
        ERR_OVERFLOW = 3'd6,
        ERR_BAD_CP   = 3'd7
    } t_err;

    // Results caused by one input byte: up to four data bytes or one status beat
    typedef struct packed {
        logic [2:0]      count;
        logic            status;
        t_err            err;
        logic            seg_done;
        logic [3:0][7:0] bytes;
    } t_result_set;

    localparam logic [20:0] CODE_MAX   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] ASCII_MAX  = 21'h00007F;
    localparam logic [20:0] TWO_MAX    = 21'h0007FF;
    localparam logic [20:0] THREE_MAX  = 21'h00FFFF;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

endpackage

/* rtl/xed_decode.sv */
// Entity state and per-byte decode: builds the result set of one accepted byte.
module xed_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output xed_pkg::t_result_set o_set
);
    import xed_pkg::*;

    // Entity state
    logic            r_in_entity, n_in_entity;
    logic            r_drop, n_drop;
    logic [3:0][7:0] r_name, n_name;
    logic [2:0]      r_len, n_len;
    logic            r_numeric, n_numeric;
    logic            r_hex, n_hex;
    logic [1:0]      r_digits, n_digits;
    logic [20:0]     r_code, n_code;
    t_err            r_pend, n_pend;

    logic [7:0]  dig_tmp;
    logic [3:0]  dig_val;
    logic        dig_ok;
    logic [25:0] acc_mul;
    logic [25:0] acc_sum;
    logic        acc_over;
    logic [2:0]      utf_cnt;
    logic [3:0][7:0] utf_bytes;
    logic        bad_cp;
    logic        name_ok;
    logic [7:0]  name_byte;
    t_result_set set;

    // Digit classification of the incoming byte
    always_comb begin
        dig_ok  = 1'b0;
        dig_tmp = 8'd0;
        if (i_byte >= "0" && i_byte <= "9") begin
            dig_ok  = 1'b1;
            dig_tmp = i_byte - 8'h30;
        end else if (r_hex && i_byte >= "a" && i_byte <= "f") begin
            dig_ok  = 1'b1;
            dig_tmp = i_byte - 8'h57;
        end else if (r_hex && i_byte >= "A" && i_byte <= "F") begin
            dig_ok  = 1'b1;
            dig_tmp = i_byte - 8'h37;
        end
        dig_val = dig_tmp[3:0];
    end

    // value * base + digit, by shifts; overflow past the top code point
    always_comb begin
        if (r_hex) begin
            acc_mul = {1'b0, r_code, 4'b0000};
        end else begin
            acc_mul = {2'b00, r_code, 3'b000} + {4'b0000, r_code, 1'b0};
        end
        acc_sum  = acc_mul + {22'd0, dig_val};
        acc_over = acc_sum > {5'd0, CODE_MAX};
    end

    // UTF-8 encoding and code point check of the accumulated value
    always_comb begin
        utf_bytes = '0;
        if (r_code <= ASCII_MAX) begin
            utf_cnt      = 3'd1;
            utf_bytes[0] = r_code[7:0];
        end else if (r_code <= TWO_MAX) begin
            utf_cnt      = 3'd2;
            utf_bytes[0] = {3'b110, r_code[10:6]};
            utf_bytes[1] = {2'b10, r_code[5:0]};
        end else if (r_code <= THREE_MAX) begin
            utf_cnt      = 3'd3;
            utf_bytes[0] = {4'b1110, r_code[15:12]};
            utf_bytes[1] = {2'b10, r_code[11:6]};
            utf_bytes[2] = {2'b10, r_code[5:0]};
        end else begin
            utf_cnt      = 3'd4;
            utf_bytes[0] = {5'b11110, r_code[20:18]};
            utf_bytes[1] = {2'b10, r_code[17:12]};
            utf_bytes[2] = {2'b10, r_code[11:6]};
            utf_bytes[3] = {2'b10, r_code[5:0]};
        end
        bad_cp = (r_code == 21'd0) || (r_code > CODE_MAX)
              || (r_code >= SURR_LO && r_code <= SURR_HI)
              || (r_code < 21'h20 && r_code != 21'h09 && r_code != 21'h0A
                  && r_code != 21'h0D);
    end

    // Named entity match
    always_comb begin
        name_ok   = 1'b1;
        name_byte = 8'h00;
        if (r_len == 3'd2 && r_name[0] == "l" && r_name[1] == "t") begin
            name_byte = CH_LT;
        end else if (r_len == 3'd2 && r_name[0] == "g" && r_name[1] == "t") begin
            name_byte = CH_GT;
        end else if (r_len == 3'd3 && r_name[0] == "a" && r_name[1] == "m"
                     && r_name[2] == "p") begin
            name_byte = CH_AMP;
        end else if (r_len == 3'd4 && r_name[0] == "q" && r_name[1] == "u"
                     && r_name[2] == "o" && r_name[3] == "t") begin
            name_byte = CH_QUOT;
        end else if (r_len == 3'd4 && r_name[0] == "a" && r_name[1] == "p"
                     && r_name[2] == "o" && r_name[3] == "s") begin
            name_byte = CH_APOS;
        end else begin
            name_ok = 1'b0;
        end
    end

    // Next state and result set
    always_comb begin
        n_in_entity = r_in_entity;
        n_drop      = r_drop;
        n_name      = r_name;
        n_len       = r_len;
        n_numeric   = r_numeric;
        n_hex       = r_hex;
        n_digits    = r_digits;
        n_code      = r_code;
        n_pend      = r_pend;

        set          = '0;
        set.err      = ERR_NONE;
        set.seg_done = i_last;

        if (r_drop) begin
            // segment already failed: swallow bytes
        end else if (!r_in_entity) begin
            if (i_byte != CH_AMP) begin
                set.count    = 3'd1;
                set.bytes[0] = i_byte;
            end else if (i_last) begin
                set.count  = 3'd1;
                set.status = 1'b1;
                set.err    = ERR_UNTERM;
            end else begin
                n_in_entity = 1'b1;
                n_len       = 3'd0;
                n_numeric   = 1'b0;
                n_hex       = 1'b0;
                n_digits    = 2'd0;
                n_code      = 21'd0;
                n_pend      = ERR_NONE;
            end
        end else if (i_byte == CH_SEMI) begin
            n_in_entity = 1'b0;
            if (r_numeric && r_len >= 3'd2) begin
                if (r_digits == 2'd0) begin
                    set.count  = 3'd1;
                    set.status = 1'b1;
                    set.err    = ERR_EMPTY;
                end else if (r_pend != ERR_NONE) begin
                    set.count  = 3'd1;
                    set.status = 1'b1;
                    set.err    = r_pend;
                end else if (bad_cp) begin
                    set.count  = 3'd1;
                    set.status = 1'b1;
                    set.err    = ERR_BAD_CP;
                end else begin
                    set.count = utf_cnt;
                    set.bytes = utf_bytes;
                end
            end else if (name_ok) begin
                set.count    = 3'd1;
                set.bytes[0] = name_byte;
            end else begin
                set.count  = 3'd1;
                set.status = 1'b1;
                set.err    = ERR_UNSUPP;
            end
        end else if (i_last) begin
            set.count  = 3'd1;
            set.status = 1'b1;
            set.err    = ERR_UNTERM;
        end else begin
            // body byte of the entity
            if (r_len < 3'd4) begin
                n_name[r_len[1:0]] = i_byte;
            end
            if (r_len == 3'd0) begin
                if (i_byte == CH_HASH) begin
                    n_numeric = 1'b1;
                end
            end else if (r_numeric) begin
                if (r_len == 3'd1 && (i_byte == "x" || i_byte == "X")) begin
                    n_hex = 1'b1;
                end else begin
                    if (r_digits < 2'd2) begin
                        n_digits = r_digits + 2'd1;
                    end
                    if (r_pend == ERR_NONE) begin
                        if (!dig_ok) begin
                            n_pend = r_hex ? ERR_BAD_HEX : ERR_BAD_DEC;
                        end else if (acc_over) begin
                            n_pend = ERR_OVERFLOW;
                        end else begin
                            n_code = acc_sum[20:0];
                        end
                    end
                end
            end
            if (r_len < 3'd7) begin
                n_len = r_len + 3'd1;
            end
        end

        // an error closes the segment and drops the rest of it
        if (set.status) begin
            set.seg_done = 1'b1;
            n_drop       = 1'b1;
            n_in_entity  = 1'b0;
        end

        // end of segment returns to the reset state
        if (i_last) begin
            n_in_entity = 1'b0;
            n_drop      = 1'b0;
            n_len       = 3'd0;
            n_numeric   = 1'b0;
            n_hex       = 1'b0;
            n_digits    = 2'd0;
            n_code      = 21'd0;
            n_pend      = ERR_NONE;
        end
    end

    assign o_set = set;

    // State registers, updated on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_entity <= 1'b0;
            r_drop      <= 1'b0;
            r_len       <= 3'd0;
            r_numeric   <= 1'b0;
            r_hex       <= 1'b0;
            r_digits    <= 2'd0;
            r_code      <= 21'd0;
            r_pend      <= ERR_NONE;
        end else if (i_accept) begin
            r_in_entity <= n_in_entity;
            r_drop      <= n_drop;
            r_len       <= n_len;
            r_numeric   <= n_numeric;
            r_hex       <= n_hex;
            r_digits    <= n_digits;
            r_code      <= n_code;
            r_pend      <= n_pend;
        end
    end

    // Entity name bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_name <= n_name;
        end
    end

endmodule

/* rtl/xml_entity_decoder.sv */
// Top level of the XML entity decoder: input handshake, decode and result buffer.
//
// Usage:
//   s_axis carries one raw byte of a text segment per beat; tlast marks the
//   final byte of the segment. m_axis carries the results: tdata holds the
//   decoded byte and the error code, tuser flags data versus status and the
//   last result of an input byte, tlast marks the result that closes the
//   segment (its last byte, or the first error).
//   An accepted input beat presents its first result in the next cycle; a byte
//   with zero or one result leaves the input free, so plain text streams at one
//   byte per cycle while the receiver is ready. A numeric reference that closes
//   into a multi-byte UTF-8 sequence occupies the result register until all its
//   bytes are delivered and holds the input until only the last one remains;
//   the serializer of that register sets the rate. Input is taken while the
//   last pending result is being delivered, so a stalled receiver stops the
//   input only once the result register is full. After an error the rest of
//   the segment is consumed without results; the receiver discards bytes of
//   that segment already delivered. Reset (synchronous, active low) empties the
//   result register and returns the decoder to the outside-entity state.
module xml_entity_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // segment_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] run_last
    output logic        m_axis_tlast    // segment_done
);
    import xed_pkg::*;

    t_result_set dec_set;
    t_result_set r_set, n_set;
    logic [2:0]  r_rem, n_rem;
    logic        in_acc;
    logic        out_acc;

    // Take input when the result register is empty or empties this cycle
    assign s_axis_tready = (r_rem == 3'd0) || (r_rem == 3'd1 && m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    xed_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_set    (dec_set)
    );

    // Result register: load a new set or shift out one result
    always_comb begin
        n_set = r_set;
        n_rem = r_rem;
        if (in_acc) begin
            n_set = dec_set;
            n_rem = dec_set.count;
        end else if (out_acc) begin
            n_set.bytes = {8'h00, r_set.bytes[3:1]};
            n_rem       = r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set <= n_set;
    end

    // Output beat
    assign m_axis_tvalid = (r_rem != 3'd0);
    assign m_axis_tdata  = {5'd0, r_set.err, r_set.bytes[0]};
    assign m_axis_tuser  = {(r_rem == 3'd1), !r_set.status};
    assign m_axis_tlast  = (r_rem == 3'd1) && r_set.seg_done;

endmodule

/* rtl/xed_checker.sv */
// Port-level checks for the XML entity decoder, bound to the top level.
module xed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A status beat closes the segment and ends its input's results
    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1])
        else $error("status beat without segment close");

    // Data beats carry no error code, status beats always do
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[10:8] == 3'd0) == m_axis_tuser[0]))
        else $error("error code does not match beat kind");

    // Segment close is always the last result of its input byte
    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("segment closed before the byte's last result");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed under stall");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (.*);

/* verif/xed_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the XML entity decoder: predicts result beats and checks them in order.
module xed_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // segment_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    input  logic [1:0]  i_m_tuser,   // [0] byte_valid, [1] run_last
    input  logic        i_m_tlast,   // segment_done
    output int          o_fail_count,
    output int          o_pending,
    output int          o_live_beats
);
    import xed_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       seg_done;
        t_err       err;
    } t_out_beat;

    // Decoder shadow state
    logic        in_entity;
    logic        drop_rest;
    logic        is_numeric;
    logic        is_hex;
    logic [7:0]  body [4];
    logic [2:0]  body_len;
    logic [1:0]  digits_seen;
    int unsigned code_acc;
    t_err        digit_err;

    t_out_beat   run_q[$];        // beats caused by the current input byte
    t_out_beat   decoded_q[$];    // beats still owed by the block

    string       entity_names[5] = '{"lt", "gt", "amp", "quot", "apos"};
    logic [7:0]  entity_chars[5] = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS};

    function void clear_body();
        for (int i = 0; i < 4; i++)
            body[i] = 8'h00;
        body_len    = 3'd0;
        is_numeric  = 1'b0;
        is_hex      = 1'b0;
        digits_seen = 2'd0;
        code_acc    = 0;
        digit_err   = ERR_NONE;
    endfunction

    function void clear_decoder();
        in_entity = 1'b0;
        drop_rest = 1'b0;
        clear_body();
    endfunction

    function void put_data(input logic [7:0] v);
        run_q.insert(run_q.size(), '{data: v, valid: 1'b1, run_last: 1'b0, seg_done: 1'b0,
                                     err: ERR_NONE});
    endfunction

    // Status beat: closes the segment, remaining bytes are swallowed
    function void put_error(input t_err e);
        run_q.insert(run_q.size(), '{data: 8'h00, valid: 1'b0, run_last: 1'b0,
                                     seg_done: 1'b1, err: e});
        drop_rest = 1'b1;
        in_entity = 1'b0;
    endfunction

    function void put_utf8(input int unsigned cp);
        if (cp <= ASCII_MAX) begin
            put_data(8'(cp));
        end else if (cp <= TWO_MAX) begin
            put_data(8'hC0 | 8'((cp >> 6) & 'h1F));
            put_data(8'h80 | 8'(cp & 'h3F));
        end else if (cp <= THREE_MAX) begin
            put_data(8'hE0 | 8'((cp >> 12) & 'h0F));
            put_data(8'h80 | 8'((cp >> 6) & 'h3F));
            put_data(8'h80 | 8'(cp & 'h3F));
        end else begin
            put_data(8'hF0 | 8'((cp >> 18) & 'h07));
            put_data(8'h80 | 8'((cp >> 12) & 'h3F));
            put_data(8'h80 | 8'((cp >> 6) & 'h3F));
            put_data(8'h80 | 8'(cp & 'h3F));
        end
    endfunction

    // Accumulate one digit; only the first digit error of an entity sticks
    function void add_digit(input logic [7:0] c);
        int unsigned d;
        int unsigned radix;
        radix = is_hex ? 16 : 10;
        if (digits_seen < 2'd2)
            digits_seen++;
        if (digit_err != ERR_NONE)
            return;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
        end else if (is_hex && c >= "a" && c <= "f") begin
            d = c - "a" + 10;
        end else if (is_hex && c >= "A" && c <= "F") begin
            d = c - "A" + 10;
        end else begin
            digit_err = is_hex ? ERR_BAD_HEX : ERR_BAD_DEC;
            return;
        end
        if (code_acc > (int'(CODE_MAX) - d) / radix) begin
            digit_err = ERR_OVERFLOW;
            return;
        end
        code_acc = code_acc * radix + d;
    endfunction

    function void absorb_body(input logic [7:0] c);
        if (body_len < 3'd4)
            body[body_len[1:0]] = c;
        if (body_len == 3'd0) begin
            if (c == CH_HASH)
                is_numeric = 1'b1;
        end else if (is_numeric) begin
            if (body_len == 3'd1 && (c == "x" || c == "X"))
                is_hex = 1'b1;
            else
                add_digit(c);
        end
        if (body_len < 3'd7)
            body_len++;
    endfunction

    function bit body_is(input string s);
        if (body_len != s.len())
            return 1'b0;
        for (int i = 0; i < s.len() && i < 4; i++)
            if (body[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Terminating ';' seen: decode the collected body
    function void close_entity();
        logic bad_ctl;
        logic hit;
        hit = 1'b0;
        in_entity = 1'b0;
        if (is_numeric && body_len >= 3'd2) begin
            bad_ctl = code_acc < 'h20 && code_acc != 'h09 && code_acc != 'h0A &&
                      code_acc != 'h0D;
            if (digits_seen == 2'd0)
                put_error(ERR_EMPTY);
            else if (digit_err != ERR_NONE)
                put_error(digit_err);
            else if (code_acc == 0 || code_acc > CODE_MAX || bad_ctl ||
                     (code_acc >= SURR_LO && code_acc <= SURR_HI))
                put_error(ERR_BAD_CP);
            else
                put_utf8(code_acc);
        end else begin
            for (int i = 0; i < 5; i++) begin
                if (!hit && body_is(entity_names[i])) begin
                    put_data(entity_chars[i]);
                    hit = 1'b1;
                end
            end
            if (!hit)
                put_error(ERR_UNSUPP);
        end
    endfunction

    function void predict_beat(input logic [7:0] b, input logic last);
        t_out_beat tail;
        run_q.delete();
        if (drop_rest) begin
            if (last)
                clear_decoder();
            return;
        end
        if (!in_entity) begin
            if (b != CH_AMP) begin
                put_data(b);
            end else if (last) begin
                put_error(ERR_UNTERM);
            end else begin
                clear_body();
                in_entity = 1'b1;
            end
        end else if (b == CH_SEMI) begin
            close_entity();
        end else if (last) begin
            put_error(ERR_UNTERM);
        end else begin
            absorb_body(b);
        end
        // Flag the final beat of this byte's run
        if (run_q.size() > 0) begin
            tail = run_q[run_q.size() - 1];
            tail.run_last = 1'b1;
            if (last)
                tail.seg_done = 1'b1;
            run_q[run_q.size() - 1] = tail;
        end
        if (last)
            clear_decoder();
        foreach (run_q[i])
            decoded_q.insert(decoded_q.size(), run_q[i]);
    endfunction

    // Compare result beats first, then predict from the input beat
    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            clear_decoder();
            decoded_q.delete();
            o_fail_count = 0;
            o_live_beats = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{data: i_m_tdata[7:0], valid: i_m_tuser[0], run_last: i_m_tuser[1],
                        seg_done: i_m_tlast, err: t_err'(i_m_tdata[10:8])};
                if (decoded_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected data=%02h valid=%0b last=%0b done=%0b err=%0d",
                                 $realtime, got.data, got.valid, got.run_last, got.seg_done,
                                 got.err);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch exp data=%02h valid=%0b last=%0b done=%0b err=%0d",
                                     $realtime, want.data, want.valid, want.run_last,
                                     want.seg_done, want.err);
                            $display("    got data=%02h valid=%0b last=%0b done=%0b err=%0d",
                                     got.data, got.valid, got.run_last, got.seg_done,
                                     got.err);
                        end
                        o_fail_count++;
                    end
                end
            end
            // Every accepted input beat counts, dropped ones included
            if (i_s_tvalid && i_s_tready) begin
                o_live_beats++;
                predict_beat(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

/* verif/tb_xml_entity_decoder.sv */
`timescale 1ns / 1ps
// Testbench top for the XML entity decoder: reset, segment stimulus, back-pressure, verdict.
module tb_xml_entity_decoder;
    import xed_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BEATS    = 105;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data  = 8'h00;
    logic        s_last  = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int live_beats;

    int phase_idle[4]  = '{0, 64, 0, 10};
    int phase_stall[4] = '{0, 0, 64, 10};

    logic [7:0] seg_bytes[$];
    string      entity_names[5] = '{"lt", "gt", "amp", "quot", "apos"};
    string      name_letters    = "aglmopqstu";

    xml_entity_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    xed_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_m_tlast    (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_beats (live_beats)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** xml_entity_decoder: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Append one byte to the segment being built
    function void add_byte(input logic [7:0] b);
        seg_bytes.insert(seg_bytes.size(), b);
    endfunction

    function void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // Plain bytes, '&' mostly avoided so entities stay well formed
    function void add_plain();
        logic [7:0] b;
        repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_AMP && $urandom_range(0, 7) != 0)
                b = "A";
            add_byte(b);
        end
    endfunction

    // Numeric reference with values aimed at each UTF-8 length and the range edges
    function automatic void add_numeric();
        int unsigned v;
        int unsigned edges[19] = '{0, 9, 10, 13, 'h1F, 'h20, 'h7F, 'h80, 'h7FF, 'h800,
                                   'hD7FF, 'hD800, 'hDFFF, 'hE000, 'hFFFF, 'h10000,
                                   'h10FFFF, 'h110000, 'hFFFFFFF};
        bit    hex;
        string digits;
        int    start;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(32, 127);
            2:       v = $urandom_range(128, 'h7FF);
            3:       v = $urandom_range('h800, 'hFFFF);
            4:       v = $urandom_range('h10000, 'h10FFFF);
            5, 6:    v = edges[$urandom_range(0, 18)];
            7:       v = $urandom_range(0, 31);
            8:       v = $urandom;
            default: v = $urandom_range(1, 'h10FFFF);
        endcase
        hex = 1'($urandom_range(0, 1));
        digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0)
            digits = {"00", digits};
        if ($urandom_range(0, 19) == 0)
            digits = "";
        add_text(hex ? ($urandom_range(0, 1) ? "&#x" : "&#X") : "&#");
        start = seg_bytes.size();
        add_text(digits);
        for (int k = start; k < seg_bytes.size(); k++)
            if (seg_bytes[k] >= "a" && seg_bytes[k] <= "f" && $urandom_range(0, 1))
                seg_bytes[k] = seg_bytes[k] - 8'h20;
        // occasionally a bad digit
        if (seg_bytes.size() > start && $urandom_range(0, 9) == 0)
            seg_bytes[$urandom_range(start, seg_bytes.size() - 1)] =
                8'($urandom_range(0, 255));
        add_byte(CH_SEMI);
    endfunction

    // Named entity, or a near miss / garbage body
    function void add_named();
        if ($urandom_range(0, 3) != 0) begin
            add_text({"&", entity_names[$urandom_range(0, 4)], ";"});
        end else begin
            add_byte(CH_AMP);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 3) == 0)
                    add_byte(8'($urandom_range(0, 255)));
                else
                    add_byte(name_letters[$urandom_range(0, name_letters.len() - 1)]);
            end
            add_byte(CH_SEMI);
        end
    endfunction

    function void build_segment();
        logic [7:0] b;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_plain();
                4, 5, 6:    add_numeric();
                7, 8:       add_named();
                default:
                    repeat ($urandom_range(1, 3))
                        add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        // segment that ends inside an entity
        if ($urandom_range(0, 9) == 0) begin
            add_byte(CH_AMP);
            repeat ($urandom_range(0, 3)) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_SEMI)
                    b = "q";
                add_byte(b);
            end
        end
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
    endtask

    task automatic play_segment();
        for (int i = 0; i < seg_bytes.size(); i++)
            send_beat(seg_bytes[i], i == seg_bytes.size() - 1);
        seg_bytes.delete();
    endtask

    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, lone '&' at the end, bare '#', empty hex,
        // a named entity, a four-byte sequence, dropping after an error
        add_byte(8'h00);
        add_byte(8'hFF);
        play_segment();
        add_text("&");
        play_segment();
        add_text("&#;a");
        play_segment();
        add_text("&#x;");
        play_segment();
        add_text("&lt;");
        play_segment();
        add_text("&#x1F600;");
        play_segment();

        // Random segments under each idling mix
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            target    = live_beats + PHASE_BEATS;
            while (live_beats < target) begin
                build_segment();
                play_segment();
            end
        end
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** xml_entity_decoder: PASSED **");
        else
            $display("** xml_entity_decoder: FAILED **");
        $finish;
    end

endmodule
